[hdl/montgomery_mul_p5x2e248_core_macros.svh]
// Assertion macros for the Montgomery multiplier core.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef MONTGOMERY_MUL_P5X2E248_CORE_MACROS_SVH
`define MONTGOMERY_MUL_P5X2E248_CORE_MACROS_SVH

// same-cycle implication, disabled in reset
`define MMP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled in reset
`define MMP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[hdl/mmp_pkg.sv]
// Shared constants, types and helpers for the Montgomery multiplier core.
// No dependencies; used by every module of the block.
package mmp_pkg;

    localparam int LIMB_COUNT = 9;
    localparam int LIMB_BITS  = 29;
    localparam int IDX_W      = 4;
    localparam int COL_W      = 5;

    localparam logic [31:0] FOLD_CONST = 32'h0005_0000;
    localparam logic [31:0] LIMB_MASK  = 32'((64'd1 << LIMB_BITS) - 64'd1);

    localparam logic [IDX_W-1:0] LAST_IDX       = IDX_W'(LIMB_COUNT - 1);
    localparam logic [COL_W-1:0] FIRST_FOLD_COL = COL_W'(LIMB_COUNT - 1);
    localparam logic [COL_W-1:0] FIRST_RES_COL  = COL_W'(LIMB_COUNT);
    localparam logic [COL_W-1:0] LAST_COL       = COL_W'(2 * LIMB_COUNT - 2);

    localparam logic CMD_MUL = 1'b0;
    localparam logic CMD_RED = 1'b1;

    // term entering the multiply-accumulate unit
    typedef struct packed {
        logic             vld;
        logic             last;
        logic [COL_W-1:0] col;
    } mmp_tag_t;

    // finished column from the multiply-accumulate unit
    typedef struct packed {
        logic                 vld;
        logic [COL_W-1:0]     col;
        logic [LIMB_BITS-1:0] low;
        logic [31:0]          high;
    } mmp_col_t;

    function automatic logic [31:0] mmp_asr(input logic [31:0] x);
        mmp_asr = {{LIMB_BITS{x[31]}}, x[31:LIMB_BITS]};
    endfunction

endpackage

[hdl/montgomery_mul_p5x2e248_core.sv]
// Montgomery multiply / reduce core for p = 5*2^248-1, radix 2^29, nine limbs.
// Depends on mmp_pkg, mmp_opstore, mmp_mac and the core macro header.
//
// Nine input words load one limb each of a and b (command in s_tuser of the
// first word). The core then drops s_tready and issues the 81 limb products
// and 9 fold terms of the product-scanning multiply, one per cycle, through a
// single shared multiplier, then waits for the last column to drain. Command
// 1 then runs two carry passes over the result store, one limb per cycle.
// Nine result words follow, the last with m_tlast. s_tready stays low until
// the last result word has been taken, so a new group cannot overlap the
// current one.
`include "montgomery_mul_p5x2e248_core_macros.svh"

module montgomery_mul_p5x2e248_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [31:0] a_limb, [63:32] b_limb
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_limb
    output logic        m_tuser,   // [0] is_zero
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_MUL,
        ST_DRAIN,
        ST_PROP,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic                      vld;
        logic                      last;
        logic                      fold;
        logic                      jzero;
        logic [mmp_pkg::COL_W-1:0] col;
    } iss_t;

    state_t                    state_reg, state_next;
    logic [mmp_pkg::IDX_W-1:0] limb_cnt_reg, limb_cnt_next;
    logic                      mode_reg, mode_next;
    logic [mmp_pkg::COL_W-1:0] col_reg, col_next;
    logic [mmp_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                      fold_reg, fold_next;
    logic                      pass_reg, pass_next;
    logic                      neg_reg, neg_next;
    logic                      nz_reg, nz_next;
    logic                      zero_reg, zero_next;
    iss_t                      iss_reg, iss_next;
    logic [31:0]               carry_reg, carry_next;

    logic [31:0]               v_reg   [mmp_pkg::LIMB_COUNT];
    logic [31:0]               res_reg [mmp_pkg::LIMB_COUNT];

    logic                      ld_en;
    logic [mmp_pkg::IDX_W-1:0] rd_b_addr;
    logic [31:0]               rd_a, rd_b;
    logic [mmp_pkg::IDX_W-1:0] hi_idx;
    logic [mmp_pkg::IDX_W-1:0] vidx;
    logic [31:0]               mac_x, mac_y;
    mmp_pkg::mmp_tag_t         mac_tag;
    mmp_pkg::mmp_col_t         mac_col;
    logic                      prop_wr;
    logic [31:0]               prop_val;
    logic [31:0]               cur;
    logic [31:0]               t;

    assign ld_en     = s_tvalid & s_tready;
    assign rd_b_addr = mmp_pkg::IDX_W'(col_reg - {1'b0, idx_reg});

    mmp_opstore u_store (
        .aclk      (aclk),
        .wr_en     (ld_en),
        .wr_addr   (limb_cnt_reg),
        .wr_a      (s_tdata[31:0]),
        .wr_b      (s_tdata[63:32]),
        .rd_a_addr (idx_reg),
        .rd_b_addr (rd_b_addr),
        .rd_a      (rd_a),
        .rd_b      (rd_b)
    );

    always_comb begin
        vidx = mmp_pkg::IDX_W'(iss_reg.col - mmp_pkg::FIRST_FOLD_COL);
        if (iss_reg.fold) begin
            mac_x = v_reg[vidx];
            mac_y = mmp_pkg::FOLD_CONST;
        end else begin
            mac_x = rd_a;
            mac_y = (mode_reg == mmp_pkg::CMD_RED) ? {31'd0, iss_reg.jzero} : rd_b;
        end
        mac_tag.vld  = iss_reg.vld;
        mac_tag.last = iss_reg.last;
        mac_tag.col  = iss_reg.col;
    end

    mmp_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (s_tready),
        .tag_i   (mac_tag),
        .x_i     (mac_x),
        .y_i     (mac_y),
        .col_o   (mac_col)
    );

    always_comb begin
        state_next    = state_reg;
        limb_cnt_next = limb_cnt_reg;
        mode_next     = mode_reg;
        col_next      = col_reg;
        idx_next      = idx_reg;
        fold_next     = fold_reg;
        pass_next     = pass_reg;
        neg_next      = neg_reg;
        nz_next       = nz_reg;
        zero_next     = zero_reg;
        carry_next    = carry_reg;
        iss_next      = '0;
        prop_wr       = 1'b0;
        prop_val      = '0;
        cur           = res_reg[idx_reg];
        t             = '0;
        hi_idx        = (col_reg >= mmp_pkg::FIRST_FOLD_COL) ? mmp_pkg::LAST_IDX
                                                             : col_reg[mmp_pkg::IDX_W-1:0];

        unique case (state_reg)
            ST_LOAD: begin
                if (ld_en) begin
                    if (limb_cnt_reg == '0) begin
                        mode_next = s_tuser;
                    end
                    if (limb_cnt_reg == mmp_pkg::LAST_IDX) begin
                        limb_cnt_next = '0;
                        state_next    = ST_MUL;
                        col_next      = '0;
                        idx_next      = '0;
                        fold_next     = 1'b0;
                    end else begin
                        limb_cnt_next = limb_cnt_reg + 1'b1;
                    end
                end
            end
            ST_MUL: begin
                iss_next.vld   = 1'b1;
                iss_next.col   = col_reg;
                iss_next.fold  = fold_reg;
                iss_next.jzero = (col_reg == {1'b0, idx_reg});
                iss_next.last  = fold_reg |
                                 ((idx_reg == hi_idx) && (col_reg < mmp_pkg::FIRST_FOLD_COL));
                if (fold_reg) begin
                    fold_next = 1'b0;
                    if (col_reg == mmp_pkg::LAST_COL) begin
                        state_next = ST_DRAIN;
                    end else begin
                        col_next = col_reg + 1'b1;
                        idx_next = mmp_pkg::IDX_W'(col_reg - (mmp_pkg::FIRST_FOLD_COL - 1'b1));
                    end
                end else if (idx_reg == hi_idx) begin
                    if (col_reg >= mmp_pkg::FIRST_FOLD_COL) begin
                        fold_next = 1'b1;
                    end else begin
                        col_next = col_reg + 1'b1;
                        idx_next = '0;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (mac_col.vld && (mac_col.col == mmp_pkg::LAST_COL)) begin
                    idx_next  = '0;
                    pass_next = 1'b0;
                    zero_next = 1'b0;
                    state_next = (mode_reg == mmp_pkg::CMD_RED) ? ST_PROP : ST_OUT;
                end
            end
            ST_PROP: begin
                prop_wr = 1'b1;
                if (idx_reg == '0) begin
                    t          = cur + (pass_reg ? {32{neg_reg}} : 32'd1);
                    prop_val   = t & mmp_pkg::LIMB_MASK;
                    carry_next = mmp_pkg::mmp_asr(t);
                end else if (idx_reg == mmp_pkg::LAST_IDX) begin
                    t = cur + carry_reg + (pass_reg ? (mmp_pkg::FOLD_CONST & {32{neg_reg}})
                                                    : (32'd0 - mmp_pkg::FOLD_CONST));
                    prop_val = t;
                end else begin
                    t          = carry_reg + cur;
                    prop_val   = t & mmp_pkg::LIMB_MASK;
                    carry_next = mmp_pkg::mmp_asr(t);
                end
                nz_next = ((idx_reg == '0) ? 1'b0 : nz_reg) | (|prop_val);
                if (idx_reg == mmp_pkg::LAST_IDX) begin
                    idx_next = '0;
                    if (!pass_reg) begin
                        pass_next = 1'b1;
                        neg_next  = t[31];
                    end else begin
                        zero_next  = ~nz_next;
                        state_next = ST_OUT;
                    end
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    if (idx_reg == mmp_pkg::LAST_IDX) begin
                        idx_next   = '0;
                        state_next = ST_LOAD;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            limb_cnt_reg <= '0;
            mode_reg     <= 1'b0;
            col_reg      <= '0;
            idx_reg      <= '0;
            fold_reg     <= 1'b0;
            pass_reg     <= 1'b0;
            neg_reg      <= 1'b0;
            nz_reg       <= 1'b0;
            zero_reg     <= 1'b0;
            iss_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            limb_cnt_reg <= limb_cnt_next;
            mode_reg     <= mode_next;
            col_reg      <= col_next;
            idx_reg      <= idx_next;
            fold_reg     <= fold_next;
            pass_reg     <= pass_next;
            neg_reg      <= neg_next;
            nz_reg       <= nz_next;
            zero_reg     <= zero_next;
            iss_reg      <= iss_next;
        end
    end

    // datapath stores, no reset
    always_ff @(posedge aclk) begin
        carry_reg <= carry_next;
        if (mac_col.vld) begin
            if (mac_col.col < mmp_pkg::FIRST_RES_COL) begin
                v_reg[mac_col.col[mmp_pkg::IDX_W-1:0]] <= 32'(mac_col.low);
            end else begin
                res_reg[mmp_pkg::IDX_W'(mac_col.col - mmp_pkg::FIRST_RES_COL)] <=
                    32'(mac_col.low);
                if (mac_col.col == mmp_pkg::LAST_COL) begin
                    res_reg[mmp_pkg::LAST_IDX] <= mac_col.high;
                end
            end
        end
        if (prop_wr) begin
            res_reg[idx_reg] <= prop_val;
        end
    end

    assign s_tready = (state_reg == ST_LOAD);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = res_reg[idx_reg];
    assign m_tuser  = zero_reg;
    assign m_tlast  = (idx_reg == mmp_pkg::LAST_IDX);

    `MMP_ASSERT_IMP(a_ready_excl, aclk, aresetn, s_tready, !m_tvalid)
    `MMP_ASSERT_IMP(a_mac_busy, aclk, aresetn, mac_col.vld, (state_reg == ST_MUL) || (state_reg == ST_DRAIN))
    `MMP_ASSERT_NXT(a_last_reload, aclk, aresetn, m_tvalid && m_tready && m_tlast, s_tready && (limb_cnt_reg == '0))
    `MMP_ASSERT_IMP(a_mul_flag, aclk, aresetn, m_tvalid && (mode_reg == mmp_pkg::CMD_MUL), !m_tuser)

endmodule

[hdl/mmp_opstore.sv]
// Operand store: two 9 x 32 limb memories for a and b, one write port,
// one registered read port each. Depends on mmp_pkg.
module mmp_opstore (
    input  logic                      aclk,
    input  logic                      wr_en,
    input  logic [mmp_pkg::IDX_W-1:0] wr_addr,
    input  logic [31:0]               wr_a,
    input  logic [31:0]               wr_b,
    input  logic [mmp_pkg::IDX_W-1:0] rd_a_addr,
    input  logic [mmp_pkg::IDX_W-1:0] rd_b_addr,
    output logic [31:0]               rd_a,
    output logic [31:0]               rd_b
);

    logic [31:0] a_mem [mmp_pkg::LIMB_COUNT];
    logic [31:0] b_mem [mmp_pkg::LIMB_COUNT];
    logic [31:0] a_rd_reg;
    logic [31:0] b_rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            a_mem[wr_addr] <= wr_a;
            b_mem[wr_addr] <= wr_b;
        end
        a_rd_reg <= a_mem[rd_a_addr];
        b_rd_reg <= b_mem[rd_b_addr];
    end

    assign rd_a = a_rd_reg;
    assign rd_b = b_rd_reg;

endmodule

[hdl/mmp_mac.sv]
// Shared 32x32 multiplier with a 64-bit column accumulator.
// Registered product, then add; a column closes on a tagged last term.
// Depends on mmp_pkg.
module mmp_mac (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clr,
    input  mmp_pkg::mmp_tag_t tag_i,
    input  logic [31:0]       x_i,
    input  logic [31:0]       y_i,
    output mmp_pkg::mmp_col_t col_o
);

    logic [63:0]       prod_reg;
    mmp_pkg::mmp_tag_t tag_reg;
    logic [63:0]       acc_reg;
    logic [63:0]       acc_next;
    mmp_pkg::mmp_col_t out_reg;
    mmp_pkg::mmp_col_t out_next;
    logic [63:0]       sum;

    always_comb begin
        sum           = acc_reg + prod_reg;
        acc_next      = acc_reg;
        out_next.vld  = tag_reg.vld & tag_reg.last;
        out_next.col  = tag_reg.col;
        out_next.low  = sum[mmp_pkg::LIMB_BITS-1:0];
        out_next.high = sum[mmp_pkg::LIMB_BITS+31:mmp_pkg::LIMB_BITS];
        if (clr) begin
            acc_next = '0;
        end else if (tag_reg.vld) begin
            acc_next = tag_reg.last ? (sum >> mmp_pkg::LIMB_BITS) : sum;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(x_i) * 64'(y_i);
        acc_reg  <= acc_next;
        out_reg.col  <= out_next.col;
        out_reg.low  <= out_next.low;
        out_reg.high <= out_next.high;
        tag_reg.last <= tag_i.last;
        tag_reg.col  <= tag_i.col;
        if (!aresetn) begin
            tag_reg.vld <= 1'b0;
            out_reg.vld <= 1'b0;
        end else begin
            tag_reg.vld <= tag_i.vld;
            out_reg.vld <= out_next.vld;
        end
    end

    assign col_o = out_reg;

endmodule
